### hdl/abpu_pkg.sv
// shared types, widths and codes of the adams-bashforth point update core
// no dependencies; imported by the history memory and by the top level

package abpu_pkg;

    // fixed field widths
    localparam int ADDR_W  = 12;
    localparam int POINTS  = 1 << ADDR_W;
    localparam int VAL_W   = 32;
    localparam int STEP_W  = 2;
    localparam int CFG_W   = 32;

    // datapath widths
    localparam int C_W     = 38;          // 23*f0 - 16*f1 + 5*f2 fits here
    localparam int MAG_W   = C_W - 1;     // magnitude of the combination
    localparam int LO_W    = MAG_W + 17;  // mag * dt_low plus rounding term
    localparam int CHUNK_W = 27;          // one digit group of the divide by three
    localparam int T_W     = 2 * CHUNK_W; // mag * dt / 2^16 before the divide
    localparam int SUM_W   = T_W + 2;

    // scheme register codes, also used as the applied order
    localparam logic [1:0] SCHEME_AB1  = 2'd0;
    localparam logic [1:0] SCHEME_AB2  = 2'd1;
    localparam logic [1:0] SCHEME_AB3  = 2'd2;
    localparam logic [1:0] SCHEME_NONE = 2'd3;

    // register indexes of the configuration port
    localparam logic REG_SCHEME    = 1'b0;
    localparam logic REG_TIME_STEP = 1'b1;

    localparam logic [CFG_W-1:0] TIME_STEP_RESET = 32'h0001_0000;

    // half of the divisor scaled by 2^16, added before truncation
    localparam logic [LO_W-1:0] HALF_D1  = 54'd32768;
    localparam logic [LO_W-1:0] HALF_D2  = 54'd65536;
    localparam logic [LO_W-1:0] HALF_D12 = 54'd393216;

    localparam logic signed [VAL_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [VAL_W-1:0] VAL_MIN = 32'sh8000_0000;

    // ceil(2^30 / 3), exact for dividends below 2^29
    localparam int                  DIV3_SHIFT = 30;
    localparam logic [CHUNK_W+1:0]  RECIP3     = 29'd357913942;

    typedef struct packed {
        logic [VAL_W-1:0] older;
        logic [VAL_W-1:0] oldest;
    } hist_entry_t;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] addr;
        hist_entry_t       entry;
    } hist_wr_t;

    // quotient of a value below 3 * 2^CHUNK_W by three
    function automatic logic [CHUNK_W-1:0] div3_q(input logic [CHUNK_W+1:0] v);
        logic [2*(CHUNK_W+2)-1:0] p;
        p = v * RECIP3;
        return p[DIV3_SHIFT+CHUNK_W-1:DIV3_SHIFT];
    endfunction

endpackage

### hdl/abpu_hist.sv
// tendency history memory: one entry per grid point holding the two previous tendencies
// depends on abpu_pkg for the entry and write request types

module abpu_hist import abpu_pkg::*; (
    input  logic              aclk,
    input  logic              en,
    input  logic [ADDR_W-1:0] rd_addr,
    input  hist_wr_t          wr,
    output hist_entry_t       rd_data
);

    hist_entry_t mem [POINTS];
    hist_entry_t rd_data_reg;

    // read-first: a read and write to the same entry on one edge returns the old entry
    always_ff @(posedge aclk) begin
        if (wr.we) begin
            mem[wr.addr] <= wr.entry;
        end
        if (en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### hdl/adams_bashforth_point_update_core.sv
// adams-bashforth point update core on abpu_pkg and the abpu_hist history memory
// eight register stages, the first loaded at the input transfer; one transfer per cycle
// sustained while results are taken; all stages advance together
// and hold while a finished result waits, so a stall loses and repeats nothing
// reset (aresetn, synchronous, active low) clears every stage valid bit and resets the scheme and
// time_step registers; the history memory reads undefined until a point has been written

module adams_bashforth_point_update_core import abpu_pkg::*; (
    input  logic                    aclk,
    input  logic                    aresetn,

    // configuration writes
    input  logic                    cfg_wr_en,
    input  logic                    cfg_index,
    input  logic [CFG_W-1:0]        cfg_data,

    // grid point input
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic [ADDR_W-1:0]       s_point_index,
    input  logic signed [VAL_W-1:0] s_state_value,
    input  logic signed [VAL_W-1:0] s_new_tendency,
    input  logic [STEP_W-1:0]       s_step_index,

    // updated value output
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic [ADDR_W-1:0]       m_result_index,
    output logic signed [VAL_W-1:0] m_new_state_value,
    output logic                    m_error
);

    // ---------------------------------------------------------------
    // configuration registers
    // ---------------------------------------------------------------
    logic [1:0]       scheme_reg;
    logic [CFG_W-1:0] time_step_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scheme_reg    <= SCHEME_AB1;
            time_step_reg <= TIME_STEP_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_SCHEME:    scheme_reg    <= cfg_data[1:0];
                REG_TIME_STEP: time_step_reg <= cfg_data;
                default:       scheme_reg    <= scheme_reg;
            endcase
        end
    end

    // ---------------------------------------------------------------
    // pipeline control: all stages move together whenever the output
    // register is empty or its result is being taken
    // ---------------------------------------------------------------
    logic en;
    logic m_valid_reg;

    assign en      = !m_valid_reg || m_ready;
    assign s_ready = en;

    // stage 1: captured input, history read data lines up with it
    logic                    r1_valid_reg;
    logic [ADDR_W-1:0]       r1_idx_reg;
    logic signed [VAL_W-1:0] r1_state_reg;
    logic signed [VAL_W-1:0] r1_f0_reg;
    logic [STEP_W-1:0]       r1_step_reg;

    // stage 2: combined tendency
    logic                    r2_valid_reg;
    logic [ADDR_W-1:0]       r2_idx_reg;
    logic signed [VAL_W-1:0] r2_state_reg;
    logic signed [VAL_W-1:0] r2_f0_reg;
    logic signed [VAL_W-1:0] r2_f1_reg;
    logic signed [C_W-1:0]   r2_c_reg;
    logic [1:0]              r2_ord_reg;
    logic                    r2_err_reg;

    // stage 3: sign and magnitude
    logic                    r3_valid_reg;
    logic [ADDR_W-1:0]       r3_idx_reg;
    logic signed [VAL_W-1:0] r3_state_reg;
    logic [1:0]              r3_ord_reg;
    logic                    r3_err_reg;
    logic                    r3_neg_reg;
    logic [MAG_W-1:0]        r3_mag_reg;

    // stage 4: low partial product with rounding term
    logic                    r4_valid_reg;
    logic [ADDR_W-1:0]       r4_idx_reg;
    logic signed [VAL_W-1:0] r4_state_reg;
    logic [1:0]              r4_ord_reg;
    logic                    r4_err_reg;
    logic                    r4_neg_reg;
    logic [MAG_W-1:0]        r4_mag_reg;
    logic [LO_W-1:0]         r4_lo_reg;

    // stage 5: full scaled product over 2^16
    logic                    r5_valid_reg;
    logic [ADDR_W-1:0]       r5_idx_reg;
    logic signed [VAL_W-1:0] r5_state_reg;
    logic [1:0]              r5_ord_reg;
    logic                    r5_err_reg;
    logic                    r5_neg_reg;
    logic [T_W-1:0]          r5_t_reg;

    // stage 6: upper digit group of the quotient
    logic                    r6_valid_reg;
    logic [ADDR_W-1:0]       r6_idx_reg;
    logic signed [VAL_W-1:0] r6_state_reg;
    logic                    r6_err_reg;
    logic                    r6_neg_reg;
    logic                    r6_div3_reg;
    logic [CHUNK_W-1:0]      r6_qhi_reg;
    logic [1:0]              r6_rem_reg;
    logic [CHUNK_W-1:0]      r6_lo_reg;

    // stage 7: full rounded increment magnitude
    logic                    r7_valid_reg;
    logic [ADDR_W-1:0]       r7_idx_reg;
    logic signed [VAL_W-1:0] r7_state_reg;
    logic                    r7_err_reg;
    logic                    r7_neg_reg;
    logic [T_W-1:0]          r7_q_reg;

    // stage 8: output register
    logic [ADDR_W-1:0]       m_idx_reg;
    logic signed [VAL_W-1:0] m_value_reg;
    logic                    m_err_reg;

    // ---------------------------------------------------------------
    // history memory, read at the transfer, written as stage 1 advances
    // ---------------------------------------------------------------
    hist_wr_t    hist_wr;
    hist_entry_t hist_rd;

    abpu_hist u_hist (
        .aclk    (aclk),
        .en      (en),
        .rd_addr (s_point_index),
        .wr      (hist_wr),
        .rd_data (hist_rd)
    );

    // ---------------------------------------------------------------
    // stage 1 logic: bypass, order selection, tendency combination
    // ---------------------------------------------------------------
    logic                    fwd;
    logic signed [VAL_W-1:0] f1_eff;
    logic signed [VAL_W-1:0] f2_eff;
    logic [1:0]              step_m1;
    logic [1:0]              ord1;
    logic                    err1;
    logic signed [C_W-1:0]   f0x;
    logic signed [C_W-1:0]   f1x;
    logic signed [C_W-1:0]   f2x;
    logic signed [C_W-1:0]   c1;

    always_comb begin
        // the item one stage ahead wrote on the same edge this one read, so
        // its history is taken from the pipe rather than from memory
        fwd    = r2_valid_reg && !r2_err_reg && (r2_idx_reg == r1_idx_reg);
        f1_eff = fwd ? r2_f0_reg : $signed(hist_rd.older);
        f2_eff = fwd ? r2_f1_reg : $signed(hist_rd.oldest);

        // step zero runs as step one; order is limited by the startup step
        step_m1 = (r1_step_reg == 2'd0) ? 2'd0 : r1_step_reg - 2'd1;
        ord1    = (scheme_reg < step_m1) ? scheme_reg : step_m1;
        err1    = (scheme_reg == SCHEME_NONE);

        f0x = C_W'(r1_f0_reg);
        f1x = C_W'(f1_eff);
        f2x = C_W'(f2_eff);

        unique case (ord1)
            SCHEME_AB1: c1 = f0x;
            SCHEME_AB2: c1 = (f0x <<< 1) + f0x - f1x;
            SCHEME_AB3: c1 = (f0x <<< 4) + (f0x <<< 2) + (f0x <<< 1) + f0x
                             - (f1x <<< 4) + (f2x <<< 2) + f2x;
            default:    c1 = f0x;
        endcase

        // rotate history: oldest takes older, older takes the new tendency
        hist_wr.we           = en && r1_valid_reg && !err1;
        hist_wr.addr         = r1_idx_reg;
        hist_wr.entry.older  = r1_f0_reg;
        hist_wr.entry.oldest = f1_eff;
    end

    // ---------------------------------------------------------------
    // stage 2..7 logic
    // ---------------------------------------------------------------
    logic                 r3_neg_next;
    logic [MAG_W-1:0]     r3_mag_next;
    logic [MAG_W+15:0]    lo_prod;
    logic [LO_W-1:0]      half_d;
    logic [LO_W-1:0]      r4_lo_next;
    logic [MAG_W+15:0]    hi_prod;
    logic [T_W-1:0]       r5_t_next;
    logic [T_W-1:0]       u6;
    logic                 div3_6;
    logic [CHUNK_W+1:0]   hi_ext;
    logic [CHUNK_W-1:0]   r6_qhi_next;
    logic [CHUNK_W+1:0]   back3;
    logic [1:0]           r6_rem_next;
    logic [CHUNK_W+1:0]   v7;
    logic [CHUNK_W-1:0]   qlo7;

    always_comb begin
        // sign and magnitude of the combination
        r3_neg_next = r2_c_reg[C_W-1];
        r3_mag_next = r3_neg_next ? MAG_W'(-r2_c_reg) : MAG_W'(r2_c_reg);

        // mag * dt_low plus d * 2^15 for round half away from zero
        unique case (r3_ord_reg)
            SCHEME_AB2: half_d = HALF_D2;
            SCHEME_AB3: half_d = HALF_D12;
            default:    half_d = HALF_D1;
        endcase
        lo_prod    = r3_mag_reg * time_step_reg[15:0];
        r4_lo_next = LO_W'(lo_prod) + half_d;

        // floor((mag * dt + d * 2^15) / 2^16)
        hi_prod   = r4_mag_reg * time_step_reg[31:16];
        r5_t_next = T_W'(hi_prod) + T_W'(r4_lo_reg[LO_W-1:16]);

        // divide by 1, 2 or 12: shift, then long division by three in two digit groups
        unique case (r5_ord_reg)
            SCHEME_AB2: u6 = r5_t_reg >> 1;
            SCHEME_AB3: u6 = r5_t_reg >> 2;
            default:    u6 = r5_t_reg;
        endcase
        div3_6      = (r5_ord_reg == SCHEME_AB3);
        hi_ext      = {2'b00, u6[T_W-1:CHUNK_W]};
        r6_qhi_next = div3_6 ? div3_q(hi_ext) : u6[T_W-1:CHUNK_W];
        back3       = {1'b0, r6_qhi_next, 1'b0} + {2'b00, r6_qhi_next};
        r6_rem_next = div3_6 ? 2'(hi_ext - back3) : 2'd0;

        // lower group carries the remainder of the upper one
        v7   = {r6_rem_reg, r6_lo_reg};
        qlo7 = r6_div3_reg ? div3_q(v7) : r6_lo_reg;
    end

    // ---------------------------------------------------------------
    // output stage: apply increment and saturate
    // ---------------------------------------------------------------
    logic signed [SUM_W-1:0] sx;
    logic signed [SUM_W-1:0] qx;
    logic signed [SUM_W-1:0] sum8;
    logic signed [VAL_W-1:0] sat8;

    always_comb begin
        sx   = SUM_W'(r7_state_reg);
        qx   = $signed({2'b00, r7_q_reg});
        sum8 = r7_neg_reg ? (sx - qx) : (sx + qx);
        priority if (sum8 > SUM_W'(VAL_MAX)) begin
            sat8 = VAL_MAX;
        end else if (sum8 < SUM_W'(VAL_MIN)) begin
            sat8 = VAL_MIN;
        end else begin
            sat8 = sum8[VAL_W-1:0];
        end
    end

    // ---------------------------------------------------------------
    // valid bits
    // ---------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            r1_valid_reg <= 1'b0;
            r2_valid_reg <= 1'b0;
            r3_valid_reg <= 1'b0;
            r4_valid_reg <= 1'b0;
            r5_valid_reg <= 1'b0;
            r6_valid_reg <= 1'b0;
            r7_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else if (en) begin
            r1_valid_reg <= s_valid;
            r2_valid_reg <= r1_valid_reg;
            r3_valid_reg <= r2_valid_reg;
            r4_valid_reg <= r3_valid_reg;
            r5_valid_reg <= r4_valid_reg;
            r6_valid_reg <= r5_valid_reg;
            r7_valid_reg <= r6_valid_reg;
            m_valid_reg  <= r7_valid_reg;
        end
    end

    // ---------------------------------------------------------------
    // payload registers
    // ---------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (en) begin
            r1_idx_reg   <= s_point_index;
            r1_state_reg <= s_state_value;
            r1_f0_reg    <= s_new_tendency;
            r1_step_reg  <= s_step_index;

            r2_idx_reg   <= r1_idx_reg;
            r2_state_reg <= r1_state_reg;
            r2_f0_reg    <= r1_f0_reg;
            r2_f1_reg    <= f1_eff;
            r2_c_reg     <= c1;
            r2_ord_reg   <= ord1;
            r2_err_reg   <= err1;

            r3_idx_reg   <= r2_idx_reg;
            r3_state_reg <= r2_state_reg;
            r3_ord_reg   <= r2_ord_reg;
            r3_err_reg   <= r2_err_reg;
            r3_neg_reg   <= r3_neg_next;
            r3_mag_reg   <= r3_mag_next;

            r4_idx_reg   <= r3_idx_reg;
            r4_state_reg <= r3_state_reg;
            r4_ord_reg   <= r3_ord_reg;
            r4_err_reg   <= r3_err_reg;
            r4_neg_reg   <= r3_neg_reg;
            r4_mag_reg   <= r3_mag_reg;
            r4_lo_reg    <= r4_lo_next;

            r5_idx_reg   <= r4_idx_reg;
            r5_state_reg <= r4_state_reg;
            r5_ord_reg   <= r4_ord_reg;
            r5_err_reg   <= r4_err_reg;
            r5_neg_reg   <= r4_neg_reg;
            r5_t_reg     <= r5_t_next;

            r6_idx_reg   <= r5_idx_reg;
            r6_state_reg <= r5_state_reg;
            r6_err_reg   <= r5_err_reg;
            r6_neg_reg   <= r5_neg_reg;
            r6_div3_reg  <= div3_6;
            r6_qhi_reg   <= r6_qhi_next;
            r6_rem_reg   <= r6_rem_next;
            r6_lo_reg    <= u6[CHUNK_W-1:0];

            r7_idx_reg   <= r6_idx_reg;
            r7_state_reg <= r6_state_reg;
            r7_err_reg   <= r6_err_reg;
            r7_neg_reg   <= r6_neg_reg;
            r7_q_reg     <= {r6_qhi_reg, qlo7};

            // unsupported scheme echoes the incoming value
            m_idx_reg    <= r7_idx_reg;
            m_value_reg  <= r7_err_reg ? r7_state_reg : sat8;
            m_err_reg    <= r7_err_reg;
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_result_index    = m_idx_reg;
    assign m_new_state_value = m_value_reg;
    assign m_error           = m_err_reg;

    // ---------------------------------------------------------------
    // assertions
    // ---------------------------------------------------------------
    // history must not change while the pipe is held
    a_no_write_in_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        !en |-> !hist_wr.we)
        else $error("history written while pipeline stalled");

    // only a live item under a supported scheme rotates history
    a_write_has_item: assert property (@(posedge aclk) disable iff (!aresetn)
        hist_wr.we |-> (r1_valid_reg && scheme_reg != SCHEME_NONE))
        else $error("history write without a valid supported item");

    // a result appears only when stage 7 held an item and the pipe advanced
    a_result_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(r7_valid_reg && en))
        else $error("result valid without a source item");

endmodule
